// ===== design/pbw_pkg.sv =====
// ----------------------------------------------------------------------------
// pbw_pkg
// Shared constants, types and the arctangent table for the beam weight block.
// ----------------------------------------------------------------------------
package pbw_pkg;

   localparam int MaxSide      = 8;
   localparam int CordicStages = 16;
   localparam int CordicW      = 34;
   localparam int CsrIndexW    = 4;

   localparam logic [CsrIndexW-1:0] CSR_ARRAY_SIDE      = 4'd0;
   localparam logic [CsrIndexW-1:0] CSR_ELEMENT_SPACING = 4'd1;

   localparam logic signed [CordicW-1:0] CORDIC_GAIN_INV = 34'sd652032874;
   localparam logic signed [CordicW-1:0] QUARTER_TURN    = 34'sd1073741824;
   localparam logic signed [CordicW-1:0] HALF_TURN       = 34'sd2147483648;

   typedef struct packed {
      logic [2:0] col;
      logic [2:0] row;
      logic       last;
   } tag_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [CordicW-1:0] atan_turn(input logic [3:0] i);
      logic signed [CordicW-1:0] a;
      case (i)
         4'd0:    a = 34'sd536870912;
         4'd1:    a = 34'sd316933406;
         4'd2:    a = 34'sd167458907;
         4'd3:    a = 34'sd85004756;
         4'd4:    a = 34'sd42667331;
         4'd5:    a = 34'sd21354465;
         4'd6:    a = 34'sd10679838;
         4'd7:    a = 34'sd5340245;
         4'd8:    a = 34'sd2670163;
         4'd9:    a = 34'sd1335087;
         4'd10:   a = 34'sd667544;
         4'd11:   a = 34'sd333772;
         4'd12:   a = 34'sd166886;
         4'd13:   a = 34'sd83443;
         4'd14:   a = 34'sd41722;
         default: a = 34'sd20861;
      endcase
      return a;
   endfunction

endpackage

// ===== design/pbw_cordic.sv =====
// ----------------------------------------------------------------------------
// pbw_cordic
// Pipelined rotation cordic: 16-bit binary angle in, Q1.15 cosine and sine out.
// ----------------------------------------------------------------------------
module pbw_cordic (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [15:0]            in_angle,
   input  pbw_pkg::tag_type       in_tag,
   output logic                   out_valid,
   output logic signed [15:0]     out_cos,
   output logic signed [15:0]     out_sin,
   output pbw_pkg::tag_type       out_tag
);

   localparam int N = pbw_pkg::CordicStages;
   localparam int W = pbw_pkg::CordicW;

   logic signed [W-1:0] x_ff [0:N];
   logic signed [W-1:0] y_ff [0:N];
   logic signed [W-1:0] z_ff [0:N];
   logic                flip_ff [0:N];
   pbw_pkg::tag_type    tag_ff [0:N];
   logic [N:0]          valid_ff;

   logic signed [W-1:0] x_in [0:N];
   logic signed [W-1:0] y_in [0:N];
   logic signed [W-1:0] z_in [0:N];
   logic signed [W-1:0] z_raw;

   logic signed [W-1:0] xf, yf, xr, yr;
   logic signed [15:0]  cos_in, sin_in;
   logic                valid_out_ff;
   logic signed [15:0]  cos_ff, sin_ff;
   pbw_pkg::tag_type    tag_out_ff;

   function automatic logic signed [15:0] sat15(input logic signed [W-1:0] v);
      logic signed [W-1:0] r;
      r = (v + W'(16384)) >>> 15;
      if (r > W'(32767))
         return 16'sh7fff;
      else if (r < -W'(32768))
         return 16'sh8000;
      else
         return r[15:0];
   endfunction

   // range reduction into plus or minus a quarter turn, then the rotation stages
   always_comb begin
      z_raw = $signed({{2{in_angle[15]}}, in_angle, 16'b0});
      x_in[0] = pbw_pkg::CORDIC_GAIN_INV;
      y_in[0] = '0;
      z_in[0] = z_raw;
      if (z_raw > pbw_pkg::QUARTER_TURN)
         z_in[0] = z_raw - pbw_pkg::HALF_TURN;
      else if (z_raw < -pbw_pkg::QUARTER_TURN)
         z_in[0] = z_raw + pbw_pkg::HALF_TURN;
      for (int i = 0; i < N; i++) begin
         if (z_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - pbw_pkg::atan_turn(4'(i));
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + pbw_pkg::atan_turn(4'(i));
         end
      end
   end

   always_comb begin
      xf     = flip_ff[N] ? -x_ff[N] : x_ff[N];
      yf     = flip_ff[N] ? -y_ff[N] : y_ff[N];
      xr     = xf;
      yr     = yf;
      cos_in = sat15(xr);
      sin_in = sat15(yr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         valid_out_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= {valid_ff[N-1:0], in_valid};
         valid_out_ff <= valid_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i <= N; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
         flip_ff[0] <= (z_raw > pbw_pkg::QUARTER_TURN) || (z_raw < -pbw_pkg::QUARTER_TURN);
         tag_ff[0]  <= in_tag;
         for (int i = 0; i < N; i++) begin
            flip_ff[i+1] <= flip_ff[i];
            tag_ff[i+1]  <= tag_ff[i];
         end
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
         tag_out_ff <= tag_ff[N];
      end
   end

   assign out_valid = valid_out_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_tag   = tag_out_ff;

endmodule

// ===== design/planar_array_beam_weights.sv =====
// ----------------------------------------------------------------------------
// planar_array_beam_weights
// Steering direction in, one complex weight per array element out.
// ----------------------------------------------------------------------------
// Each accepted direction yields side*side weights, row by row, one per cycle
// while rsp_ready is high; a side of 0 gives one weight and one above 8 gives 64.
// The direction passes through two cordic pipelines (18 stages) that find the
// direction cosines, two multiply stages that form the phase steps, and an
// 18-stage element cordic that turns each phase into a weight. The next
// direction is taken as soon as the previous one has been handed to the
// element sequencer.
module planar_array_beam_weights (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_elevation_angle,
   input  logic signed [15:0]  req_azimuth_angle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_column_index,
   output logic [2:0]          rsp_row_index,
   output logic signed [15:0]  rsp_weight_real,
   output logic signed [15:0]  rsp_weight_imag,
   output logic                rsp_last_weight,
   input  logic                csr_we,
   input  logic [pbw_pkg::CsrIndexW-1:0] csr_index,
   input  logic [15:0]         csr_wdata
);

   logic [3:0]  side_ff;
   logic [15:0] spacing_ff;

   logic        busy_ff;
   logic        req_fire;

   logic               el_valid, az_valid;
   logic signed [15:0] ce, se, ca, sa;
   pbw_pkg::tag_type   el_tag, az_tag, zero_tag;

   logic               m1_valid_ff;
   logic signed [32:0] amp_ff;
   logic signed [15:0] ca_ff, sa_ff;
   logic               mul_valid_ff;
   logic signed [48:0] pc_ff, ps_ff;
   logic signed [48:0] pc_rnd, ps_rnd;

   logic        load;
   logic        gen_active_ff;
   logic [2:0]  col_ff, row_ff, last_ff;
   logic [15:0] col_step_ff, row_step_ff, elem_phase_ff, row_phase_ff;
   logic [2:0]  last_in;
   logic        en;
   pbw_pkg::tag_type gen_tag, out_tag;
   logic               out_valid;
   logic signed [15:0] w_cos, w_sin;

   assign zero_tag = '0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= 4'd8;
         spacing_ff <= 16'd8192;
      end else if (csr_we) begin
         case (csr_index)
            pbw_pkg::CSR_ARRAY_SIDE:      side_ff    <= csr_wdata[3:0];
            pbw_pkg::CSR_ELEMENT_SPACING: spacing_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;

   pbw_cordic u_el_cordic (
      .clock(clock), .reset(reset), .enable(1'b1),
      .in_valid(req_fire), .in_angle(req_elevation_angle), .in_tag(zero_tag),
      .out_valid(el_valid), .out_cos(ce), .out_sin(se), .out_tag(el_tag)
   );

   pbw_cordic u_az_cordic (
      .clock(clock), .reset(reset), .enable(1'b1),
      .in_valid(req_fire), .in_angle(req_azimuth_angle), .in_tag(zero_tag),
      .out_valid(az_valid), .out_cos(ca), .out_sin(sa), .out_tag(az_tag)
   );

   // spacing times cos(elevation), then times cos and sin of azimuth
   always_ff @(posedge clock) begin
      if (el_valid) begin
         amp_ff <= $signed({1'b0, spacing_ff}) * ce;
         ca_ff  <= ca;
         sa_ff  <= sa;
      end
      if (m1_valid_ff) begin
         pc_ff <= amp_ff * ca_ff;
         ps_ff <= amp_ff * sa_ff;
      end
   end

   assign load   = mul_valid_ff && !gen_active_ff;
   assign pc_rnd = pc_ff + 49'sd134217728;
   assign ps_rnd = ps_ff + 49'sd134217728;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         m1_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
      end else begin
         if (req_fire)
            busy_ff <= 1'b1;
         else if (load)
            busy_ff <= 1'b0;
         m1_valid_ff <= el_valid && az_valid;
         if (m1_valid_ff)
            mul_valid_ff <= 1'b1;
         else if (load)
            mul_valid_ff <= 1'b0;
      end
   end

   // element sequencer
   always_comb begin
      if (side_ff == 4'd0)
         last_in = 3'd0;
      else if (side_ff > 4'(pbw_pkg::MaxSide))
         last_in = 3'(pbw_pkg::MaxSide - 1);
      else
         last_in = 3'(side_ff - 4'd1);
   end

   assign en = !rsp_valid || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_active_ff <= 1'b0;
      end else if (load) begin
         gen_active_ff <= 1'b1;
      end else if (gen_active_ff && en && col_ff == last_ff && row_ff == last_ff) begin
         gen_active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         col_ff        <= '0;
         row_ff        <= '0;
         last_ff       <= last_in;
         col_step_ff   <= pc_rnd[43:28];
         row_step_ff   <= ps_rnd[43:28];
         elem_phase_ff <= '0;
         row_phase_ff  <= '0;
      end else if (gen_active_ff && en) begin
         if (col_ff == last_ff) begin
            col_ff        <= '0;
            row_ff        <= row_ff + 3'd1;
            row_phase_ff  <= row_phase_ff + row_step_ff;
            elem_phase_ff <= row_phase_ff + row_step_ff;
         end else begin
            col_ff        <= col_ff + 3'd1;
            elem_phase_ff <= elem_phase_ff + col_step_ff;
         end
      end
   end

   always_comb begin
      gen_tag.col  = col_ff;
      gen_tag.row  = row_ff;
      gen_tag.last = (col_ff == last_ff) && (row_ff == last_ff);
   end

   pbw_cordic u_elem_cordic (
      .clock(clock), .reset(reset), .enable(en),
      .in_valid(gen_active_ff), .in_angle(elem_phase_ff), .in_tag(gen_tag),
      .out_valid(out_valid), .out_cos(w_cos), .out_sin(w_sin), .out_tag(out_tag)
   );

   assign rsp_valid        = out_valid;
   assign rsp_column_index = out_tag.col;
   assign rsp_row_index    = out_tag.row;
   assign rsp_last_weight  = out_tag.last;
   assign rsp_weight_real  = w_cos;
   assign rsp_weight_imag  = (w_sin == 16'sh8000) ? 16'sh7fff : -w_sin;

   // direction released only when the sequencer starts its run
   assert property (@(posedge clock) disable iff (reset) $fell(busy_ff) |-> gen_active_ff)
      else $error("direction released without starting a run");
   assert property (@(posedge clock) disable iff (reset) mul_valid_ff |-> busy_ff)
      else $error("phase steps held while front end idle");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_weight |-> rsp_column_index == rsp_row_index)
      else $error("last word not on the diagonal corner");

endmodule
